>>> src/pbu_pkg.sv
// pbu_pkg: shared types and constants for the pixel block upscaler.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package pbu_pkg;

  // Field widths fixed by the register map and the stream words
  localparam int WIDTH_W = 13;
  localparam int SCALE_W = 4;
  localparam int BPP_W   = 3;
  localparam int PIX_W   = 8;
  localparam int OFS_W   = 32;
  localparam int ADDR_W  = 5;
  localparam int DATA_W  = 32;
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 56;

  // Register indexes (paddr[4:2])
  localparam logic [2:0] REG_WIDTH  = 3'd0;
  localparam logic [2:0] REG_HEIGHT = 3'd1;
  localparam logic [2:0] REG_SCALE  = 3'd2;
  localparam logic [2:0] REG_BPP    = 3'd3;
  localparam logic [2:0] REG_SWAP   = 3'd4;

  typedef struct packed {
    logic [WIDTH_W-1:0] image_width;
    logic [WIDTH_W-1:0] image_height;
    logic [SCALE_W-1:0] zoom;
    logic [BPP_W-1:0]   bytes_per_pixel;
    logic               swap_red_blue;
  } pbu_cfg_t;

  // Controller to datapath
  typedef struct packed {
    logic load;      // latch pixel, snapshot position, first products
    logic mul_a;     // stride and column byte products
    logic mul_b;     // row base product
    logic add_base;  // block start offset
    logic emit;      // load one result into the output register
  } pbu_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic blk_last;  // current write is the last of the block
    logic out_free;  // output register can take a word this cycle
  } pbu_sts_t;

endpackage

>>> src/pbu_cfg.sv
// pbu_cfg: APB-style register file for the upscaler settings.
// Depends on pbu_pkg.
`timescale 1ns / 1ps

module pbu_cfg (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [pbu_pkg::ADDR_W-1:0]   paddr,
  input  logic [pbu_pkg::DATA_W-1:0]   pwdata,
  output logic [pbu_pkg::DATA_W-1:0]   prdata,
  output pbu_pkg::pbu_cfg_t            cfg
);
  import pbu_pkg::*;

  pbu_cfg_t   cfg_r;
  logic       wr_en;
  logic [2:0] reg_idx;

  assign reg_idx = paddr[4:2];
  // pready is tied high, so setup plus access completes the write
  assign wr_en   = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.image_width     <= WIDTH_W'(1);
      cfg_r.image_height    <= WIDTH_W'(1);
      cfg_r.zoom            <= SCALE_W'(1);
      cfg_r.bytes_per_pixel <= BPP_W'(3);
      cfg_r.swap_red_blue   <= 1'b1;
    end else if (wr_en) begin
      case (reg_idx)
        REG_WIDTH:  cfg_r.image_width     <= pwdata[WIDTH_W-1:0];
        REG_HEIGHT: cfg_r.image_height    <= pwdata[WIDTH_W-1:0];
        REG_SCALE:  cfg_r.zoom            <= pwdata[SCALE_W-1:0];
        REG_BPP:    cfg_r.bytes_per_pixel <= pwdata[BPP_W-1:0];
        REG_SWAP:   cfg_r.swap_red_blue   <= pwdata[0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_WIDTH:  prdata = DATA_W'(cfg_r.image_width);
      REG_HEIGHT: prdata = DATA_W'(cfg_r.image_height);
      REG_SCALE:  prdata = DATA_W'(cfg_r.zoom);
      REG_BPP:    prdata = DATA_W'(cfg_r.bytes_per_pixel);
      REG_SWAP:   prdata = DATA_W'(cfg_r.swap_red_blue);
      default:    prdata = '0;
    endcase
  end

  assign cfg = cfg_r;

endmodule

>>> src/pbu_ctrl.sv
// pbu_ctrl: sequencer for one source pixel: setup products, then one write
// per destination pixel of the block. Depends on pbu_pkg.
`timescale 1ns / 1ps

module pbu_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  pbu_pkg::pbu_sts_t sts,
  output pbu_pkg::pbu_cmd_t cmd
);
  import pbu_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_MULA = 5'b00010,
    ST_MULB = 5'b00100,
    ST_ADD  = 5'b01000,
    ST_EMIT = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    cmd          = '0;
    in_ready     = 1'b0;
    state_nxt    = state_r;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_MULA;
        end
      end
      ST_MULA: begin
        cmd.mul_a = 1'b1;
        state_nxt = ST_MULB;
      end
      ST_MULB: begin
        cmd.mul_b = 1'b1;
        state_nxt = ST_ADD;
      end
      ST_ADD: begin
        cmd.add_base = 1'b1;
        state_nxt    = ST_EMIT;
      end
      ST_EMIT: begin
        if (sts.out_free) begin
          cmd.emit = 1'b1;
          if (sts.blk_last) state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end

endmodule

>>> src/pbu_dpath.sv
// pbu_dpath: position counters, offset arithmetic and output register.
// Depends on pbu_pkg; driven by pbu_ctrl commands.
`timescale 1ns / 1ps

module pbu_dpath #(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096,
  parameter int MAX_SCALE  = 8
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  pbu_pkg::pbu_cfg_t                 cfg,
  input  pbu_pkg::pbu_cmd_t                 cmd,
  output pbu_pkg::pbu_sts_t                 sts,
  input  logic [pbu_pkg::IN_TDATA_W-1:0]    pix_in,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [pbu_pkg::OUT_TDATA_W-1:0]   out_data,
  output logic                              out_blk,
  output logic                              out_img
);
  import pbu_pkg::*;

  localparam int CW   = (MAX_WIDTH  > 1) ? $clog2(MAX_WIDTH)  : 1;
  localparam int RW   = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int SCW  = (MAX_SCALE  > 1) ? $clog2(MAX_SCALE)  : 1;
  localparam int DW   = 17;                   // clamped dimension, up to 65536
  localparam int RSW  = RW + SCALE_W;
  localparam int CSW  = CW + SCALE_W;
  localparam int WSW  = DW + SCALE_W;
  localparam int STW  = WSW + BPP_W;
  localparam int CSBW = CSW + BPP_W;
  localparam logic [DW-1:0]      MAX_W_V = DW'(MAX_WIDTH);
  localparam logic [DW-1:0]      MAX_H_V = DW'(MAX_HEIGHT);
  localparam logic [SCALE_W-1:0] MAX_S_V = SCALE_W'(MAX_SCALE);

  // clamped settings
  logic [DW-1:0]      w_c, h_c, wcfg, hcfg;
  logic [SCALE_W-1:0] s_c;
  logic [BPP_W-1:0]   bpp_c;
  logic               last_col, last_row;

  logic [CW-1:0]      col_r;
  logic [RW-1:0]      row_r;
  logic [PIX_W-1:0]   b1_r, b2_r, b3_r;
  logic               last_pos_r;
  logic [SCALE_W-1:0] s_r;
  logic [BPP_W-1:0]   bpp_r;
  logic [RSW-1:0]     rs_r;
  logic [CSW-1:0]     cs_r;
  logic [WSW-1:0]     ws_r;
  logic [STW-1:0]     strb_r;
  logic [CSBW-1:0]    csb_r;
  logic [OFS_W-1:0]   base_r, row_start_r, cur_r;
  logic [SCW-1:0]     ri_r, ci_r;
  logic               c_end, r_end;

  logic               out_valid_r;
  logic [OFS_W-1:0]   out_ofs_r;
  logic [PIX_W-1:0]   out_b1_r, out_b2_r, out_b3_r;
  logic               out_blk_r, out_img_r;

  assign wcfg = DW'(cfg.image_width);
  assign hcfg = DW'(cfg.image_height);

  always_comb begin
    w_c = wcfg;
    if (wcfg == '0)          w_c = DW'(1);
    else if (wcfg > MAX_W_V) w_c = MAX_W_V;
    h_c = hcfg;
    if (hcfg == '0)          h_c = DW'(1);
    else if (hcfg > MAX_H_V) h_c = MAX_H_V;
    s_c = cfg.zoom;
    if (cfg.zoom == '0)          s_c = SCALE_W'(1);
    else if (cfg.zoom > MAX_S_V) s_c = MAX_S_V;
    bpp_c = cfg.bytes_per_pixel;
    if (cfg.bytes_per_pixel < BPP_W'(3))      bpp_c = BPP_W'(3);
    else if (cfg.bytes_per_pixel > BPP_W'(4)) bpp_c = BPP_W'(4);
  end

  assign last_col = (DW'(col_r) + DW'(1)) >= w_c;
  assign last_row = (DW'(row_r) + DW'(1)) >= h_c;

  // source position; moves on as soon as the pixel is taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (cmd.load) begin
      if (last_col) begin
        col_r <= '0;
        row_r <= last_row ? '0 : row_r + RW'(1);
      end else begin
        col_r <= col_r + CW'(1);
      end
    end
  end

  assign c_end = (SCALE_W'(ci_r) == s_r - SCALE_W'(1));
  assign r_end = (SCALE_W'(ri_r) == s_r - SCALE_W'(1));

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      b1_r       <= cfg.swap_red_blue ? pix_in[23:16] : pix_in[7:0];
      b2_r       <= pix_in[15:8];
      b3_r       <= cfg.swap_red_blue ? pix_in[7:0] : pix_in[23:16];
      last_pos_r <= last_col & last_row;
      s_r        <= s_c;
      bpp_r      <= bpp_c;
      rs_r       <= RSW'(row_r) * RSW'(s_c);
      cs_r       <= CSW'(col_r) * CSW'(s_c);
      ws_r       <= WSW'(w_c) * WSW'(s_c);
    end
    if (cmd.mul_a) begin
      strb_r <= STW'(ws_r) * STW'(bpp_r);        // row stride in bytes
      csb_r  <= CSBW'(cs_r) * CSBW'(bpp_r);
    end
    if (cmd.mul_b) begin
      base_r <= OFS_W'(rs_r) * OFS_W'(strb_r);   // wraps modulo 2^32
    end
    if (cmd.add_base) begin
      row_start_r <= base_r + OFS_W'(csb_r);
      cur_r       <= base_r + OFS_W'(csb_r);
      ri_r        <= '0;
      ci_r        <= '0;
    end else if (cmd.emit) begin
      if (c_end) begin
        ci_r        <= '0;
        ri_r        <= ri_r + SCW'(1);
        row_start_r <= row_start_r + OFS_W'(strb_r);
        cur_r       <= row_start_r + OFS_W'(strb_r);
      end else begin
        ci_r  <= ci_r + SCW'(1);
        cur_r <= cur_r + OFS_W'(bpp_r);
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_ofs_r <= cur_r;
      out_b1_r  <= b1_r;
      out_b2_r  <= b2_r;
      out_b3_r  <= b3_r;
      out_blk_r <= c_end & r_end;
      out_img_r <= c_end & r_end & last_pos_r;
    end
  end

  assign sts.blk_last = c_end & r_end;
  assign sts.out_free = ~out_valid_r | out_ready;

  assign out_valid = out_valid_r;
  assign out_data  = {out_b3_r, out_b2_r, out_b1_r, out_ofs_r};
  assign out_blk   = out_blk_r;
  assign out_img   = out_img_r;

endmodule

>>> src/pixel_block_upscaler.sv
// Usage: nearest-neighbor integer upscaler for raster RGB streams.
// in_*  : one source pixel per word, raster order; tdata = {blue, green, red}.
// out_* : one destination write per word; tdata = {byte_third, byte_second,
//         byte_first, dest_offset}; tuser = block_done; tlast = image_done.
// cfg_* : APB-style registers at byte addresses 0x00 width, 0x04 height,
//         0x08 scale, 0x0C bytes per pixel, 0x10 red/blue swap. Write only
//         while idle; pready is always high.
// A pixel with scale s yields s*s writes. Once the pixel is taken, the setup
// states ST_MULA, ST_MULB and ST_ADD form the block's base offset in a
// multiplier chain; the sequencer then emits one write per cycle while the
// output register can take a word. The emit phase is bound by the single
// output register.
// in_tready is high only while the sequencer is idle; it stays high even if
// the last write of the previous pixel is still waiting at the output.
// When out_tready is low and a word is waiting at the output, the sequencer
// holds its place and the output word stays put; nothing is dropped.
// Reset (rst_n low, synchronous) restores register defaults and puts the
// position counters at the top-left pixel.
// Depends on pbu_pkg, pbu_cfg, pbu_ctrl and pbu_dpath.
`timescale 1ns / 1ps

module pixel_block_upscaler #(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096,
  parameter int MAX_SCALE  = 8
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // tdata: red[7:0], green[15:8], blue[23:16]
  input  logic [pbu_pkg::IN_TDATA_W-1:0]    in_tdata,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // tdata: dest_offset[31:0], byte_first[39:32], byte_second[47:40],
  //        byte_third[55:48]
  output logic [pbu_pkg::OUT_TDATA_W-1:0]   out_tdata,
  // tuser: block_done[0]
  output logic                              out_tuser,
  output logic                              out_tlast,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  input  logic                              cfg_psel,
  input  logic                              cfg_penable,
  input  logic                              cfg_pwrite,
  input  logic [pbu_pkg::ADDR_W-1:0]        cfg_paddr,
  input  logic [pbu_pkg::DATA_W-1:0]        cfg_pwdata,
  output logic [pbu_pkg::DATA_W-1:0]        cfg_prdata,
  output logic                              cfg_pready
);
  import pbu_pkg::*;

  pbu_cfg_t cfg;
  pbu_cmd_t cmd;
  pbu_sts_t sts;
  logic     ready;

  assign cfg_pready = 1'b1;

  pbu_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .cfg     (cfg)
  );

  pbu_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  pbu_dpath #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .MAX_SCALE  (MAX_SCALE)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .cmd       (cmd),
    .sts       (sts),
    .pix_in    (in_tdata),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (out_tdata),
    .out_blk   (out_tuser),
    .out_img   (out_tlast)
  );

  assign in_tready = ready;

endmodule

>>> bench/pixel_block_upscaler_test.sv
// pixel_block_upscaler_test: self-checking bench for the nearest-neighbor pixel block upscaler.
// Directed table, then random config phases; each write checked vs in-bench model or typed row.
// Depends on pbu_pkg and pixel_block_upscaler.
`timescale 1ns / 1ps

module pixel_block_upscaler_test;
  import pbu_pkg::*;

  localparam int MAX_W = 4096;
  localparam int MAX_H = 4096;
  localparam int MAX_S = 8;

  typedef struct packed {
    logic [OFS_W-1:0] offset;
    logic [PIX_W-1:0] first;
    logic [PIX_W-1:0] second;
    logic [PIX_W-1:0] third;
    logic             blk;
    logic             img;
  } dest_write_t;

  typedef enum logic [1:0] {STEP_CFG, STEP_PIX, STEP_CHK} step_kind_t;

  typedef struct packed {
    step_kind_t  kind;
    logic [2:0]  reg_idx;
    logic [31:0] value;  // register value, or {8'h0, blue, green, red}
    dest_write_t want;   // typed-in write for STEP_CHK rows
  } step_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic [IN_TDATA_W-1:0] in_tdata = '0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic out_tuser;
  logic out_tlast;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic cfg_psel = 1'b0;
  logic cfg_penable = 1'b0;
  logic cfg_pwrite = 1'b0;
  logic [ADDR_W-1:0] cfg_paddr = '0;
  logic [DATA_W-1:0] cfg_pwdata = '0;
  logic [DATA_W-1:0] cfg_prdata;
  logic cfg_pready;

  // Model copy of the registers and the source position
  logic [WIDTH_W-1:0] cfg_width = 13'd1;
  logic [WIDTH_W-1:0] cfg_height = 13'd1;
  logic [SCALE_W-1:0] cfg_scale = 4'd1;
  logic [BPP_W-1:0]   cfg_bpp = 3'd3;
  logic               cfg_swap = 1'b1;
  logic [11:0]        src_col = '0;
  logic [11:0]        src_row = '0;

  dest_write_t pending_writes[$];
  int mismatches = 0;
  bit steady = 1'b0;  // no idling on either side while set

  step_t script [0:30];

  pixel_block_upscaler #(
    .MAX_WIDTH(MAX_W),
    .MAX_HEIGHT(MAX_H),
    .MAX_SCALE(MAX_S)
  ) i_dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_tdata(in_tdata),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .out_tlast(out_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .cfg_psel(cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr),
    .cfg_pwdata(cfg_pwdata),
    .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  always #1 clk = ~clk;

  // Expands one source pixel into its block of destination writes
  function automatic void upscale_pixel(logic [IN_TDATA_W-1:0] px);
    int unsigned w, h, s, bpp, r, c;
    logic [63:0] pix;
    logic [PIX_W-1:0] first, third;
    bit last_col, last_row;
    dest_write_t wr;
    w = (cfg_width == 0) ? 1 : (cfg_width > MAX_W) ? MAX_W : cfg_width;
    h = (cfg_height == 0) ? 1 : (cfg_height > MAX_H) ? MAX_H : cfg_height;
    s = (cfg_scale == 0) ? 1 : (cfg_scale > MAX_S) ? MAX_S : cfg_scale;
    bpp = (cfg_bpp < 3) ? 3 : (cfg_bpp > 4) ? 4 : cfg_bpp;
    last_col = int'(src_col) + 1 >= w;
    last_row = int'(src_row) + 1 >= h;
    first = cfg_swap ? px[23:16] : px[7:0];
    third = cfg_swap ? px[7:0] : px[23:16];
    for (r = 0; r < s; r++) begin
      for (c = 0; c < s; c++) begin
        pix = (64'(src_row) * s + r) * (64'(w) * s) + 64'(src_col) * s + c;
        wr.offset = 32'(pix * bpp);
        wr.first = first;
        wr.second = px[15:8];
        wr.third = third;
        wr.blk = (r == s - 1) && (c == s - 1);
        wr.img = wr.blk && last_col && last_row;
        pending_writes.push_back(wr);
      end
    end
    if (last_col) begin
      src_col = '0;
      src_row = last_row ? 12'd0 : src_row + 12'd1;
    end else begin
      src_col = src_col + 12'd1;
    end
  endfunction

  // Register write, issued only once the block has drained
  task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
    in_tvalid <= 1'b0;
    while (pending_writes.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    case (idx)
      REG_WIDTH:  cfg_width = value[WIDTH_W-1:0];
      REG_HEIGHT: cfg_height = value[WIDTH_W-1:0];
      REG_SCALE:  cfg_scale = value[SCALE_W-1:0];
      REG_BPP:    cfg_bpp = value[BPP_W-1:0];
      REG_SWAP:   cfg_swap = value[0];
      default: ;
    endcase
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  // Sends one pixel word; returns on the accepting edge with tvalid still high
  task automatic send_pixel(input logic [IN_TDATA_W-1:0] px, input bit typed,
                            input dest_write_t want, input bit hold);
    if (hold) begin
      in_tvalid <= 1'b0;
      do @(posedge clk); while (pending_writes.size() != 0);
    end else if (!steady) begin
      while ($urandom_range(0, 99) < 36) begin
        in_tvalid <= 1'b0;
        @(posedge clk);
      end
    end
    in_tdata <= px;
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    upscale_pixel(px);
    if (typed) begin
      // typed row stands in for the single predicted write
      void'(pending_writes.pop_back());
      pending_writes.push_back(want);
    end
  endtask

  function automatic logic [WIDTH_W-1:0] pick_size();
    logic [WIDTH_W-1:0] odd_sizes [5] = '{13'd0, 13'd1, 13'd4096, 13'd4097, 13'd8191};
    if ($urandom_range(0, 9) == 0) return odd_sizes[$urandom_range(0, 4)];
    return WIDTH_W'($urandom_range(1, 6));
  endfunction

  always @(posedge clk) begin : drain
    dest_write_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_writes.size() == 0) begin
        $error("unexpected write word: offset %h", out_tdata[31:0]);
        mismatches++;
      end else begin
        want = pending_writes.pop_front();
        if (out_tdata[31:0] !== want.offset) begin
          $error("dest_offset: expected %h, got %h", want.offset, out_tdata[31:0]);
          mismatches++;
        end
        if (out_tdata[39:32] !== want.first) begin
          $error("byte_first: expected %h, got %h", want.first, out_tdata[39:32]);
          mismatches++;
        end
        if (out_tdata[47:40] !== want.second) begin
          $error("byte_second: expected %h, got %h", want.second, out_tdata[47:40]);
          mismatches++;
        end
        if (out_tdata[55:48] !== want.third) begin
          $error("byte_third: expected %h, got %h", want.third, out_tdata[55:48]);
          mismatches++;
        end
        if (out_tuser !== want.blk) begin
          $error("block_done: expected %b, got %b", want.blk, out_tuser);
          mismatches++;
        end
        if (out_tlast !== want.img) begin
          $error("image_done: expected %b, got %b", want.img, out_tlast);
          mismatches++;
        end
      end
    end
    out_tready <= steady || ($urandom_range(0, 99) >= 36);
  end

  initial begin : stimulus
    int phase;
    int random_sent;
    int n_items;
    int k;
    logic [IN_TDATA_W-1:0] px;
    // reset values: 1x1 image, scale 1, 3 bytes, red/blue swapped
    script = '{
      '{STEP_CHK, REG_WIDTH,  32'h0056_3412, '{32'd0, 8'h56, 8'h34, 8'h12, 1'b1, 1'b1}},
      '{STEP_CHK, REG_WIDTH,  32'h0000_00FF, '{32'd0, 8'h00, 8'h00, 8'hFF, 1'b1, 1'b1}},
      '{STEP_CHK, REG_WIDTH,  32'h00FF_FF00, '{32'd0, 8'hFF, 8'hFF, 8'h00, 1'b1, 1'b1}},
      '{STEP_CFG, REG_SWAP,   32'd0,         '0},
      '{STEP_CHK, REG_WIDTH,  32'h00FF_55AA, '{32'd0, 8'hAA, 8'h55, 8'hFF, 1'b1, 1'b1}},
      // zero sizes, zero scale, too few bytes: all fall back to the minimum
      '{STEP_CFG, REG_WIDTH,  32'd0,         '0},
      '{STEP_CFG, REG_HEIGHT, 32'd0,         '0},
      '{STEP_CFG, REG_SCALE,  32'd0,         '0},
      '{STEP_CFG, REG_BPP,    32'd0,         '0},
      '{STEP_CHK, REG_WIDTH,  32'h007F_8001, '{32'd0, 8'h01, 8'h80, 8'h7F, 1'b1, 1'b1}},
      // oversized width and bytes per pixel clamp to 4096 and 4
      '{STEP_CFG, REG_BPP,    32'd7,         '0},
      '{STEP_CFG, REG_WIDTH,  32'h0000_1FFF, '0},
      '{STEP_CHK, REG_WIDTH,  32'h0000_0000, '{32'd0, 8'h00, 8'h00, 8'h00, 1'b1, 1'b0}},
      '{STEP_CHK, REG_WIDTH,  32'h00FF_FFFF, '{32'd4, 8'hFF, 8'hFF, 8'hFF, 1'b1, 1'b0}},
      '{STEP_CFG, REG_SWAP,   32'd1,         '0},
      '{STEP_CFG, REG_SCALE,  32'd15,        '0},
      '{STEP_PIX, REG_WIDTH,  32'h00A5_3CC3, '0},
      // shrink below the current column; upper pwdata bits are dropped
      '{STEP_CFG, REG_WIDTH,  32'hFFFF_E002, '0},
      '{STEP_CFG, REG_HEIGHT, 32'd2,         '0},
      '{STEP_PIX, REG_WIDTH,  32'h0012_8001, '0},
      '{STEP_PIX, REG_WIDTH,  32'h0080_01FE, '0},
      '{STEP_PIX, REG_WIDTH,  32'h00FE_7F10, '0},
      '{STEP_CFG, REG_HEIGHT, 32'h0000_1FFF, '0},
      '{STEP_CFG, REG_WIDTH,  32'd4096,      '0},
      '{STEP_CFG, REG_SCALE,  32'd9,         '0},
      '{STEP_CFG, REG_BPP,    32'd5,         '0},
      '{STEP_PIX, REG_WIDTH,  32'h0024_68AC, '0},
      '{STEP_CFG, REG_BPP,    32'd2,         '0},
      '{STEP_CFG, REG_SCALE,  32'd1,         '0},
      '{STEP_PIX, REG_WIDTH,  32'h00C0_FFEE, '0},
      '{STEP_PIX, REG_WIDTH,  32'h0001_0203, '0}
    };
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (script[i]) begin
      if (script[i].kind == STEP_CFG) begin
        write_reg(script[i].reg_idx, script[i].value);
      end else begin
        send_pixel(script[i].value[IN_TDATA_W-1:0], script[i].kind == STEP_CHK,
                   script[i].want, 1'b0);
      end
    end

    random_sent = 0;
    phase = 0;
    while (random_sent < 200) begin
      write_reg(REG_WIDTH, 32'(pick_size()));
      write_reg(REG_HEIGHT, 32'(pick_size()));
      if ($urandom_range(0, 7) == 0) begin
        write_reg(REG_SCALE, $urandom_range(0, 1) ? 32'd0 : 32'($urandom_range(9, 15)));
      end else begin
        write_reg(REG_SCALE, 32'($urandom_range(1, 8)));
      end
      if ($urandom_range(0, 9) < 7) begin
        write_reg(REG_BPP, 32'($urandom_range(3, 4)));
      end else begin
        write_reg(REG_BPP, 32'($urandom_range(0, 7)));
      end
      write_reg(REG_SWAP, 32'($urandom_range(0, 1)));
      steady = (phase == 1);
      n_items = steady ? 40 : $urandom_range(10, 35);
      for (k = 0; k < n_items; k++) begin
        px = IN_TDATA_W'($urandom());
        if ($urandom_range(0, 15) == 0) px = $urandom_range(0, 1) ? 24'hFF_FFFF : 24'h0;
        send_pixel(px, 1'b0, '0, (k == n_items / 2) && (phase % 2 == 0));
        random_sent++;
      end
      steady = 1'b0;
      phase++;
    end

    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending_writes.size() != 0);
    repeat (16) @(posedge clk);
    if (mismatches == 0 && pending_writes.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
